// File: hw/rtl/prg_pkg.sv
// Shared widths and defaults for the Pascal row generator.
package prg_pkg;

  // Width of the row length input and of the column index
  localparam int unsigned RowWidth = 6;
  // Width of the running value and of the truncated intermediate product
  localparam int unsigned ValueWidth = 35;
  // Width of an emitted coefficient
  localparam int unsigned CoefWidth = 31;
  // Longest row whose coefficients all stay inside the coefficient width
  localparam int unsigned MaxRowDefault = 34;

endpackage

// File: hw/rtl/pascal_row_generator_top.sv
// Pascal row generator: emits one row of binomial coefficients per request.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_ready_o   row_length_i
//   output   out        out_valid_o / out_ready_i coefficient_o, column_o, last_o
//
// A row of n entries is produced in order: the first coefficient is offered straight
// from the request, and each further one follows the transfer of the one before, one
// multiply step and 35 steps of the shared restoring divider; an output stall holds
// the sequence.
// Reset clears the sequencer and the datapath registers; no clearing pass is needed.
// A new row is taken only once the last coefficient of the previous row has been
// transferred; while an output transfer is stalled the sequencer holds its state.
module pascal_row_generator_top
  import prg_pkg::*;
#(
  parameter int unsigned MAX_ROW = MaxRowDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [RowWidth-1:0]  row_length_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CoefWidth-1:0] coefficient_o,
  output logic [RowWidth-1:0]  column_o,
  output logic                 last_o
);

  // Sequencer state codes
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StEmit = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;
  localparam logic [1:0] StDiv  = 2'd3;

  localparam int unsigned DivCntWidth = $clog2(ValueWidth);
  localparam logic [DivCntWidth-1:0] DivLastStep = DivCntWidth'(ValueWidth - 1);
  localparam logic [RowWidth-1:0] MaxRowC = RowWidth'(MAX_ROW);

  logic [1:0]             state_q, state_d;
  logic [ValueWidth-1:0]  value_q, value_d;
  logic [RowWidth-1:0]    col_q, col_d;
  logic [RowWidth-1:0]    row_q, row_d;
  logic                   last_q, last_d;
  logic [RowWidth-1:0]    rem_q, rem_d;
  logic [ValueWidth-1:0]  quo_q, quo_d;
  logic [DivCntWidth-1:0] cnt_q, cnt_d;

  logic [RowWidth-1:0]            len_sat;
  logic [RowWidth-1:0]            factor;
  logic [ValueWidth+RowWidth-1:0] product_full;
  logic [RowWidth:0]              shifted;
  logic [RowWidth:0]              trial;
  logic                           quo_bit;
  logic [RowWidth-1:0]            step_rem;
  logic [ValueWidth-1:0]          step_quo;

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = (state_q == StEmit);
  assign coefficient_o = value_q[CoefWidth-1:0];
  assign column_o      = col_q;
  assign last_o        = last_q;

  // Row lengths above the limit saturate to the longest row.
  assign len_sat = (row_length_i > MaxRowC) ? MaxRowC : row_length_i;

  // Shared multiplier: running value times the remaining row factor.
  assign factor       = row_q - col_q;
  assign product_full = value_q * {{ValueWidth{1'b0}}, factor};

  // One restoring division step; the remainder always stays below the divisor.
  assign shifted  = {rem_q, quo_q[ValueWidth-1]};
  assign trial    = shifted - {1'b0, col_q};
  assign quo_bit  = (shifted >= {1'b0, col_q});
  assign step_rem = quo_bit ? trial[RowWidth-1:0] : shifted[RowWidth-1:0];
  assign step_quo = {quo_q[ValueWidth-2:0], quo_bit};

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d = state_q;
    value_d = value_q;
    col_d   = col_q;
    row_d   = row_q;
    last_d  = last_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i && (row_length_i != '0)) begin
          row_d   = len_sat;
          value_d = ValueWidth'(1);
          col_d   = '0;
          last_d  = (len_sat == RowWidth'(1));
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_ready_i) begin
          if (last_q) begin
            state_d = StIdle;
          end else begin
            col_d   = col_q + RowWidth'(1);
            state_d = StMul;
          end
        end
      end
      StMul: begin
        quo_d   = product_full[ValueWidth-1:0];
        rem_d   = '0;
        cnt_d   = DivLastStep;
        state_d = StDiv;
      end
      StDiv: begin
        rem_d = step_rem;
        quo_d = step_quo;
        cnt_d = cnt_q - DivCntWidth'(1);
        if (cnt_q == '0) begin
          value_d = step_quo;
          last_d  = (({1'b0, col_q} + (RowWidth+1)'(1)) == {1'b0, row_q});
          state_d = StEmit;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      col_q   <= col_d;
      row_q   <= row_d;
      last_q  <= last_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
    end else begin
      value_q <= value_d;
      rem_q   <= rem_d;
      quo_q   <= quo_d;
    end
  end

  // A transfer of the last coefficient returns the block to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
    else $error("block not idle after the last transfer of a row");

  // The column never reaches the row length while a coefficient is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (column_o < row_q))
    else $error("column outside the row");

  // The last mark is set exactly on the final column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (({1'b0, column_o} + 7'd1) == {1'b0, row_q})))
    else $error("last mark does not match the column");

  // The divisor is never zero during division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (col_q != '0))
    else $error("division by zero column");

  // A non-final transfer advances the column by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> (col_q == $past(col_q) + 6'd1))
    else $error("column did not advance");

endmodule
